// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked while reset is released.
`define AMER_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked on every edge, reset included.
`define AMER_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== design/amer_pkg.sv =====
// Shared types, constants and helpers of the alpha-mask edge run extractor.
package amer_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;
    localparam int unsigned FIELD_W        = 9;
    localparam int unsigned NUM_SLOTS      = 8;
    localparam int unsigned SLOT_IDX_W     = 3;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 9;
    localparam int unsigned IN_TDATA_W     = 8;
    localparam int unsigned OUT_TDATA_W    = 32;

    localparam logic [8:0] RESET_WIDTH     = 9'd16;
    localparam logic [8:0] RESET_HEIGHT    = 9'd16;
    localparam logic [7:0] RESET_THRESHOLD = 8'd1;

    localparam logic [2:0] KIND_SOLID_ABOVE = 3'd0;
    localparam logic [2:0] KIND_SOLID_BELOW = 3'd1;
    localparam logic [2:0] KIND_SOLID_LEFT  = 3'd2;
    localparam logic [2:0] KIND_SOLID_RIGHT = 3'd3;
    localparam logic [2:0] NO_RUN           = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] stop;
    } t_run;

    typedef struct packed {
        logic [FIELD_W-1:0] stop;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] line;
        logic [1:0]         kind;
    } t_slot;

    function automatic logic [2:0] horiz_kind(input logic above, input logic below);
        if (above && !below) begin
            return KIND_SOLID_ABOVE;
        end else if (!above && below) begin
            return KIND_SOLID_BELOW;
        end
        return NO_RUN;
    endfunction

    function automatic logic [2:0] vert_kind(input logic left, input logic right);
        if (left && !right) begin
            return KIND_SOLID_LEFT;
        end else if (!left && right) begin
            return KIND_SOLID_RIGHT;
        end
        return NO_RUN;
    endfunction

endpackage

// ===== design/amer_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module amer_ram #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/amer_track.sv =====
// One boundary line tracker: closes, opens and edge-closes a run.
module amer_track #(
    parameter int unsigned PW = 9
) (
    input  logic                i_en,
    input  logic [2:0]          i_open_kind,
    input  logic [PW-1:0]       i_open_start,
    input  logic [2:0]          i_kind,
    input  logic [PW-1:0]       i_pos,
    input  logic                i_final,
    input  logic [PW-1:0]       i_edge,
    output amer_pkg::t_run      o_close,
    output amer_pkg::t_run      o_edge,
    output logic [2:0]          o_kind,
    output logic [PW-1:0]       o_start
);

    logic [2:0]    open_k;
    logic [PW-1:0] open_s;

    always_comb begin
        open_k = i_open_kind;
        open_s = i_open_start;
        o_close.valid = i_en && (open_k != amer_pkg::NO_RUN) && (open_k != i_kind);
        o_close.kind  = open_k[1:0];
        o_close.start = amer_pkg::FIELD_W'(open_s);
        o_close.stop  = amer_pkg::FIELD_W'(i_pos);
        if (open_k != i_kind) begin
            open_k = i_kind;
            open_s = i_pos;
        end
        o_edge.valid = i_en && i_final && (open_k != amer_pkg::NO_RUN);
        o_edge.kind  = open_k[1:0];
        o_edge.start = amer_pkg::FIELD_W'(open_s);
        o_edge.stop  = amer_pkg::FIELD_W'(i_edge);
        if (i_final) begin
            open_k = amer_pkg::NO_RUN;
        end
        o_kind  = open_k;
        o_start = open_s;
    end

endmodule

// ===== design/alpha_mask_edge_run_extractor.sv =====
// Alpha-mask edge run extractor: one alpha byte per request in raster order; every maximal
// solid/clear boundary run (horizontal kinds 0-1, vertical kinds 2-3) comes out as one
// request when it closes. A pixel is taken when the first stage is empty or passes its pixel
// on; its runs (zero to eight) enter the result buffer once it is empty or hands out its last
// run, and leave one per cycle through the single result port while the receiver is ready.
// Runs are tracked in a per-column RAM with registered read; no clearing pass is needed.
module alpha_mask_edge_run_extractor #(
    parameter int unsigned MAX_WIDTH  = amer_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = amer_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [amer_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [amer_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] pixel_alpha
    input  logic [amer_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] run_kind, [10:2] boundary_line, [19:11] run_start, [28:20] run_end, zero pad
    output logic [amer_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned MW = 1 + 3 + RW;
    localparam int unsigned NS = amer_pkg::NUM_SLOTS;
    localparam int unsigned SW = amer_pkg::SLOT_IDX_W;

    logic [8:0]          r_width;
    logic [8:0]          r_height;
    logic [7:0]          r_thresh;
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [2:0]          r_row_kind [2];
    logic [CW-1:0]       r_row_start [2];
    logic [2:0]          r_right_kind;
    logic [RW-1:0]       r_right_start;
    logic                r_left;

    logic                r_s1_valid;
    logic [CW-1:0]       r_s1_col;
    logic [RW-1:0]       r_s1_row;
    logic                r_s1_lc;
    logic                r_s1_lr;
    logic                r_s1_cur;
    logic                r_fwd_hit;
    logic [MW-1:0]       r_fwd_data;

    logic [NS-1:0]       r_buf_valid;
    amer_pkg::t_slot     r_buf [NS];

    logic [CW-1:0]       w;
    logic [RW-1:0]       h;
    logic                in_acc;
    logic                restart;
    logic                lc0;
    logic                lr0;
    logic                s1_move;
    logic                out_take;
    logic                buf_single;
    logic [SW-1:0]       sel;
    logic [MW-1:0]       ram_q;
    logic [MW-1:0]       q;
    logic [MW-1:0]       wdata;
    logic                above;
    logic                left;
    logic [2:0]          col_open;
    logic [2:0]          right_open;
    logic [RW-1:0]       row_p1;
    logic [CW-1:0]       col_p1;

    amer_pkg::t_run      run_c [4];
    amer_pkg::t_run      run_e [4];
    logic [2:0]          t_kind [4];
    logic [CW-1:0]       t0_start;
    logic [CW-1:0]       t1_start;
    logic [RW-1:0]       t2_start;
    logic [RW-1:0]       t3_start;

    always_comb begin
        if (r_width == 9'd0) begin
            w = CW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_width);
        end
        if (r_height == 9'd0) begin
            h = RW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(r_height);
        end
    end

    assign buf_single      = (r_buf_valid & (r_buf_valid - NS'(1))) == '0;
    assign o_m_axis_tvalid = |r_buf_valid;
    assign out_take        = o_m_axis_tvalid && i_m_axis_tready;
    assign s1_move         = r_s1_valid && ((r_buf_valid == '0) || (buf_single && out_take));
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign restart         = i_cfg_we &&
                             (i_cfg_index inside {amer_pkg::CFG_WIDTH, amer_pkg::CFG_HEIGHT});
    assign lc0             = ((CW + 1)'(r_col) + (CW + 1)'(1)) >= (CW + 1)'(w);
    assign lr0             = ((RW + 1)'(r_row) + (RW + 1)'(1)) >= (RW + 1)'(h);

    always_comb begin
        sel = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (r_buf_valid[i]) begin
                sel = SW'(i);
            end
        end
    end

    assign o_m_axis_tdata = amer_pkg::OUT_TDATA_W'(r_buf[sel]);
    assign o_m_axis_tlast = buf_single;

    amer_ram #(
        .W     (MW),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (in_acc),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign q          = r_fwd_hit ? r_fwd_data : ram_q;
    assign above      = (r_s1_row == '0) ? 1'b0 : q[MW-1];
    assign left       = (r_s1_col == '0) ? 1'b0 : r_left;
    assign col_open   = (r_s1_row == '0) ? amer_pkg::NO_RUN : q[MW-2 -: 3];
    assign right_open = (r_s1_row == '0) ? amer_pkg::NO_RUN : r_right_kind;
    assign row_p1     = r_s1_row + RW'(1);
    assign col_p1     = r_s1_col + CW'(1);

    amer_track #(.PW(CW)) u_trk_row (
        .i_en (1'b1), .i_open_kind (r_row_kind[0]), .i_open_start (r_row_start[0]),
        .i_kind (amer_pkg::horiz_kind(above, r_s1_cur)), .i_pos (r_s1_col),
        .i_final (r_s1_lc), .i_edge (w),
        .o_close (run_c[0]), .o_edge (run_e[0]), .o_kind (t_kind[0]), .o_start (t0_start)
    );

    amer_track #(.PW(CW)) u_trk_bottom (
        .i_en (r_s1_lr), .i_open_kind (r_row_kind[1]), .i_open_start (r_row_start[1]),
        .i_kind (amer_pkg::horiz_kind(r_s1_cur, 1'b0)), .i_pos (r_s1_col),
        .i_final (r_s1_lc), .i_edge (w),
        .o_close (run_c[1]), .o_edge (run_e[1]), .o_kind (t_kind[1]), .o_start (t1_start)
    );

    amer_track #(.PW(RW)) u_trk_col (
        .i_en (1'b1), .i_open_kind (col_open), .i_open_start (q[RW-1:0]),
        .i_kind (amer_pkg::vert_kind(left, r_s1_cur)), .i_pos (r_s1_row),
        .i_final (r_s1_lr), .i_edge (row_p1),
        .o_close (run_c[2]), .o_edge (run_e[2]), .o_kind (t_kind[2]), .o_start (t2_start)
    );

    amer_track #(.PW(RW)) u_trk_right (
        .i_en (r_s1_lc), .i_open_kind (right_open), .i_open_start (r_right_start),
        .i_kind (amer_pkg::vert_kind(r_s1_cur, 1'b0)), .i_pos (r_s1_row),
        .i_final (r_s1_lr), .i_edge (row_p1),
        .o_close (run_c[3]), .o_edge (run_e[3]), .o_kind (t_kind[3]), .o_start (t3_start)
    );

    assign wdata = {r_s1_cur, t_kind[2], t2_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width        <= amer_pkg::RESET_WIDTH;
            r_height       <= amer_pkg::RESET_HEIGHT;
            r_thresh       <= amer_pkg::RESET_THRESHOLD;
            r_col          <= '0;
            r_row          <= '0;
            r_row_kind[0]  <= amer_pkg::NO_RUN;
            r_row_kind[1]  <= amer_pkg::NO_RUN;
            r_row_start[0] <= '0;
            r_row_start[1] <= '0;
            r_right_kind   <= amer_pkg::NO_RUN;
            r_right_start  <= '0;
            r_left         <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_fwd_hit      <= 1'b0;
            r_buf_valid    <= '0;
        end else begin
            if (s1_move) begin
                for (int i = 0; i < 4; i++) begin
                    r_buf_valid[2*i]       <= run_c[i].valid;
                    r_buf_valid[2*i+1]     <= run_e[i].valid;
                end
            end else if (out_take) begin
                r_buf_valid[sel] <= 1'b0;
            end
            if (in_acc) begin
                r_s1_col  <= r_col;
                r_s1_row  <= r_row;
                r_s1_lc   <= lc0;
                r_s1_lr   <= lr0;
                r_s1_cur  <= i_s_axis_tdata >= r_thresh;
                r_fwd_hit <= s1_move && (r_s1_col[AW-1:0] == r_col[AW-1:0]);
                r_fwd_data <= wdata;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (restart) begin
                r_col          <= '0;
                r_row          <= '0;
                r_row_kind[0]  <= amer_pkg::NO_RUN;
                r_row_kind[1]  <= amer_pkg::NO_RUN;
                r_row_start[0] <= '0;
                r_row_start[1] <= '0;
                r_right_kind   <= amer_pkg::NO_RUN;
                r_left         <= 1'b0;
            end else begin
                if (in_acc) begin
                    if (lc0) begin
                        r_col <= '0;
                        r_row <= lr0 ? '0 : r_row + RW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                if (s1_move) begin
                    r_row_kind[0]  <= t_kind[0];
                    r_row_start[0] <= t0_start;
                    if (r_s1_lr) begin
                        r_row_kind[1]  <= t_kind[1];
                        r_row_start[1] <= t1_start;
                    end
                    if (r_s1_lc) begin
                        r_right_kind  <= t_kind[3];
                        r_right_start <= t3_start;
                    end
                    r_left <= r_s1_cur;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    amer_pkg::CFG_WIDTH: begin
                        r_width <= i_cfg_data;
                    end
                    amer_pkg::CFG_HEIGHT: begin
                        r_height <= i_cfg_data;
                    end
                    amer_pkg::CFG_THRESHOLD: begin
                        r_thresh <= i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_buf[0] <= '{stop: run_c[0].stop, start: run_c[0].start,
                          line: amer_pkg::FIELD_W'(r_s1_row), kind: run_c[0].kind};
            r_buf[1] <= '{stop: run_e[0].stop, start: run_e[0].start,
                          line: amer_pkg::FIELD_W'(r_s1_row), kind: run_e[0].kind};
            r_buf[2] <= '{stop: run_c[1].stop, start: run_c[1].start,
                          line: amer_pkg::FIELD_W'(row_p1), kind: run_c[1].kind};
            r_buf[3] <= '{stop: run_e[1].stop, start: run_e[1].start,
                          line: amer_pkg::FIELD_W'(row_p1), kind: run_e[1].kind};
            r_buf[4] <= '{stop: run_c[2].stop, start: run_c[2].start,
                          line: amer_pkg::FIELD_W'(r_s1_col), kind: run_c[2].kind};
            r_buf[5] <= '{stop: run_e[2].stop, start: run_e[2].start,
                          line: amer_pkg::FIELD_W'(r_s1_col), kind: run_e[2].kind};
            r_buf[6] <= '{stop: run_c[3].stop, start: run_c[3].start,
                          line: amer_pkg::FIELD_W'(col_p1), kind: run_c[3].kind};
            r_buf[7] <= '{stop: run_e[3].stop, start: run_e[3].start,
                          line: amer_pkg::FIELD_W'(col_p1), kind: run_e[3].kind};
        end
    end

endmodule

// ===== design/amer_checker.sv =====
// Port-level checker of the alpha-mask edge run extractor and its bind.
`include "assert_macros.svh"

module amer_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [amer_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             o_m_axis_tlast
);

    `AMER_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    `AMER_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
    `AMER_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)
    `AMER_ASSERT(a_run_nonempty, i_clk, i_rst_n,
        o_m_axis_tvalid |-> o_m_axis_tdata[28:20] > o_m_axis_tdata[19:11])

endmodule

bind alpha_mask_edge_run_extractor amer_checker u_amer_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== bench/tb.sv =====
// Self-checking bench for the alpha-mask edge run extractor: directed table, then random images.
`timescale 1ns / 1ps

module tb;

    localparam logic [amer_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [3:0] NO_CHECK = 4'hF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] line;
        logic [8:0] start;
        logic [8:0] stop;
        logic       last;
    } t_edge_run;

    typedef struct packed {
        logic             is_cfg;
        logic [1:0]       idx;
        logic [8:0]       data;
        logic [3:0]       n_runs;
        t_edge_run        first;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [amer_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [amer_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [amer_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    logic [amer_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                             o_m_axis_tlast;

    alpha_mask_edge_run_extractor u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    int         img_w;
    int         img_h;
    logic [7:0] thr;
    logic       prev_solid [256];
    logic [2:0] col_kind   [257];
    logic [8:0] col_start  [257];
    logic [2:0] row_kind   [2];
    logic [8:0] row_start  [2];
    int         col_cnt;
    int         row_cnt;
    logic       left_solid;

    t_edge_run  pixel_runs [$];
    t_edge_run  expected_runs [$];
    t_row       directed [$];

    int errors = 0;
    int cycles = 0;
    int send_pct = 0;
    int recv_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    task automatic restart_image();
        for (int i = 0; i < 257; i++) begin
            col_kind[i] = amer_pkg::NO_RUN;
            col_start[i] = '0;
        end
        for (int i = 0; i < 2; i++) begin
            row_kind[i] = amer_pkg::NO_RUN;
            row_start[i] = '0;
        end
        col_cnt = 0;
        row_cnt = 0;
        left_solid = 1'b0;
    endtask

    task automatic apply_cfg(input logic [1:0] idx, input logic [8:0] data);
        if (idx == amer_pkg::CFG_WIDTH) begin
            img_w = int'(data);
            restart_image();
        end else if (idx == amer_pkg::CFG_HEIGHT) begin
            img_h = int'(data);
            restart_image();
        end else if (idx == amer_pkg::CFG_THRESHOLD) begin
            thr = data[7:0];
        end
    endtask

    task automatic add_run(input logic [2:0] kind, input int line, input int st, input int stop);
        t_edge_run r;
        r.kind = kind[1:0];
        r.line = line[8:0];
        r.start = st[8:0];
        r.stop = stop[8:0];
        r.last = 1'b0;
        if (pixel_runs.size() < amer_pkg::NUM_SLOTS) pixel_runs.push_back(r);
    endtask

    task automatic track_line(inout logic [2:0] open, inout logic [8:0] st,
                              input logic [2:0] kind, input int line, input int pos,
                              input bit fin, input int stop_pos);
        if (open != amer_pkg::NO_RUN && open != kind) add_run(open, line, int'(st), pos);
        if (open != kind) begin
            open = kind;
            st = pos[8:0];
        end
        if (fin && open != amer_pkg::NO_RUN) begin
            add_run(open, line, int'(st), stop_pos);
            open = amer_pkg::NO_RUN;
        end
    endtask

    function automatic logic [2:0] h_kind(input logic a, input logic b);
        if (a && !b) return amer_pkg::KIND_SOLID_ABOVE;
        if (!a && b) return amer_pkg::KIND_SOLID_BELOW;
        return amer_pkg::NO_RUN;
    endfunction

    function automatic logic [2:0] v_kind(input logic l, input logic r);
        if (l && !r) return amer_pkg::KIND_SOLID_LEFT;
        if (!l && r) return amer_pkg::KIND_SOLID_RIGHT;
        return amer_pkg::NO_RUN;
    endfunction

    task automatic predict_pixel(input logic [7:0] alpha);
        int   w;
        int   h;
        int   c;
        int   r;
        bit   lc;
        bit   lr;
        logic cur;
        logic above;
        logic left;
        w = (img_w == 0) ? 1 : (img_w > 256 ? 256 : img_w);
        h = (img_h == 0) ? 1 : (img_h > 256 ? 256 : img_h);
        c = (col_cnt >= w) ? w - 1 : col_cnt;
        r = (row_cnt >= h) ? h - 1 : row_cnt;
        lc = (c + 1 >= w);
        lr = (r + 1 >= h);
        pixel_runs.delete();
        cur = (alpha >= thr);
        above = (r == 0) ? 1'b0 : prev_solid[c];
        left = (c == 0) ? 1'b0 : left_solid;
        track_line(row_kind[0], row_start[0], h_kind(above, cur), r, c, lc, w);
        if (lr) track_line(row_kind[1], row_start[1], h_kind(cur, 1'b0), r + 1, c, lc, w);
        track_line(col_kind[c], col_start[c], v_kind(left, cur), c, r, lr, r + 1);
        if (lc) track_line(col_kind[c + 1], col_start[c + 1], v_kind(cur, 1'b0),
                           c + 1, r, lr, r + 1);
        prev_solid[c] = cur;
        left_solid = cur;
        if (lc) begin
            col_cnt = 0;
            row_cnt = lr ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
        if (pixel_runs.size() > 0) pixel_runs[pixel_runs.size() - 1].last = 1'b1;
        foreach (pixel_runs[i]) expected_runs.push_back(pixel_runs[i]);
    endtask

    task automatic report(input string what, input t_edge_run exp_r, input t_edge_run act_r);
        errors++;
        if (errors <= 10)
            $display("%s: expected kind %0d line %0d start %0d end %0d last %0d,",
                     what, exp_r.kind, exp_r.line, exp_r.start, exp_r.stop, exp_r.last,
                     " got kind %0d line %0d start %0d end %0d last %0d",
                     act_r.kind, act_r.line, act_r.start, act_r.stop, act_r.last);
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_edge_run act_r;
        t_edge_run exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            act_r.kind = o_m_axis_tdata[1:0];
            act_r.line = o_m_axis_tdata[10:2];
            act_r.start = o_m_axis_tdata[19:11];
            act_r.stop = o_m_axis_tdata[28:20];
            act_r.last = o_m_axis_tlast;
            if (expected_runs.size() == 0) begin
                report("unexpected run", '0, act_r);
            end else begin
                exp_r = expected_runs.pop_front();
                if (exp_r != act_r || o_m_axis_tdata[31:29] != 3'b0) report("run", exp_r, act_r);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_runs.size() != 0 || hold_left > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [8:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_cfg(idx, data);
    endtask

    task automatic send_pixel(input logic [7:0] alpha);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= alpha;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_pixel(alpha);
        while ($urandom_range(99) < send_pct) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_row pix_row(input logic [7:0] a, input logic [3:0] n,
                                     input t_edge_run f);
        t_row rw;
        rw.is_cfg = 1'b0;
        rw.idx = '0;
        rw.data = {1'b0, a};
        rw.n_runs = n;
        rw.first = f;
        return rw;
    endfunction

    function automatic t_row cfg_row(input logic [1:0] idx, input logic [8:0] d);
        t_row rw;
        rw.is_cfg = 1'b1;
        rw.idx = idx;
        rw.data = d;
        rw.n_runs = NO_CHECK;
        rw.first = '0;
        return rw;
    endfunction

    function automatic logic [7:0] rand_alpha();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3) return 8'd0;
        if (sel < 6) return 8'd255;
        if (sel < 8) return 8'(thr + $urandom_range(2) - 1);
        return 8'($urandom_range(255));
    endfunction

    initial begin
        t_edge_run one_px;
        t_edge_run first_close;
        int        nitems;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        img_w = int'(amer_pkg::RESET_WIDTH);
        img_h = int'(amer_pkg::RESET_HEIGHT);
        thr = amer_pkg::RESET_THRESHOLD;
        foreach (prev_solid[i]) prev_solid[i] = 1'b0;
        restart_image();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        one_px = '{kind: amer_pkg::KIND_SOLID_BELOW[1:0], line: 9'd0, start: 9'd0,
                   stop: 9'd1, last: 1'b0};
        first_close = '{kind: amer_pkg::KIND_SOLID_BELOW[1:0], line: 9'd0, start: 9'd0,
                        stop: 9'd1, last: 1'b1};
        directed.push_back(pix_row(8'd0, 4'd0, '0));
        directed.push_back(cfg_row(amer_pkg::CFG_WIDTH, 9'd1));
        directed.push_back(cfg_row(amer_pkg::CFG_HEIGHT, 9'd1));
        directed.push_back(pix_row(8'd255, 4'd4, one_px));
        directed.push_back(pix_row(8'd0, 4'd0, '0));
        directed.push_back(cfg_row(amer_pkg::CFG_THRESHOLD, 9'd0));
        directed.push_back(pix_row(8'd0, 4'd4, one_px));
        directed.push_back(cfg_row(amer_pkg::CFG_THRESHOLD, 9'd255));
        directed.push_back(pix_row(8'd254, 4'd0, '0));
        directed.push_back(pix_row(8'd255, 4'd4, one_px));
        directed.push_back(cfg_row(amer_pkg::CFG_WIDTH, 9'd0));
        directed.push_back(cfg_row(amer_pkg::CFG_HEIGHT, 9'd0));
        directed.push_back(pix_row(8'd128, 4'd0, '0));
        directed.push_back(pix_row(8'd255, 4'd4, one_px));
        directed.push_back(cfg_row(amer_pkg::CFG_THRESHOLD, 9'd128));
        directed.push_back(pix_row(8'd127, 4'd0, '0));
        directed.push_back(pix_row(8'd128, 4'd4, one_px));
        directed.push_back(cfg_row(CFG_SPARE, 9'h1FF));
        directed.push_back(pix_row(8'd128, 4'd4, one_px));
        directed.push_back(cfg_row(amer_pkg::CFG_WIDTH, 9'h1FF));
        directed.push_back(cfg_row(amer_pkg::CFG_HEIGHT, 9'h1FF));
        directed.push_back(cfg_row(amer_pkg::CFG_THRESHOLD, 9'd1));
        directed.push_back(pix_row(8'd255, 4'd0, '0));
        directed.push_back(pix_row(8'd0, 4'd1, first_close));
        directed.push_back(cfg_row(amer_pkg::CFG_WIDTH, 9'd2));
        directed.push_back(cfg_row(amer_pkg::CFG_HEIGHT, 9'd2));
        directed.push_back(pix_row(8'd255, NO_CHECK, '0));
        directed.push_back(pix_row(8'd0, NO_CHECK, '0));
        directed.push_back(pix_row(8'd0, NO_CHECK, '0));
        directed.push_back(pix_row(8'd255, NO_CHECK, '0));

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                write_cfg(directed[i].idx, directed[i].data);
            end else begin
                send_pixel(directed[i].data[7:0]);
                if (directed[i].n_runs != NO_CHECK) begin
                    if (pixel_runs.size() != directed[i].n_runs)
                        report("run count", '0, '0);
                    else if (pixel_runs.size() > 0 && pixel_runs[0] != directed[i].first)
                        report("table", directed[i].first, pixel_runs[0]);
                end
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    send_pct = 0;
                    recv_pct = 0;
                end
                1: begin
                    send_pct = 71;
                    recv_pct = 0;
                end
                2: begin
                    send_pct = 0;
                    recv_pct = 71;
                end
                default: begin
                    send_pct = 35;
                    recv_pct = 35;
                end
            endcase
            if (ph == 0) begin
                write_cfg(amer_pkg::CFG_WIDTH, 9'd256);
                write_cfg(amer_pkg::CFG_HEIGHT, 9'd1);
                write_cfg(amer_pkg::CFG_THRESHOLD, 9'd1);
            end else if (ph == 7) begin
                write_cfg(amer_pkg::CFG_WIDTH, 9'd1);
                write_cfg(amer_pkg::CFG_HEIGHT, 9'd256);
                write_cfg(amer_pkg::CFG_THRESHOLD, 9'd255);
            end else begin
                write_cfg(amer_pkg::CFG_WIDTH, 9'($urandom_range(1, 9)));
                write_cfg(amer_pkg::CFG_HEIGHT, 9'($urandom_range(1, 7)));
                write_cfg(amer_pkg::CFG_THRESHOLD, 9'($urandom_range(255)));
                if (ph == 3) write_cfg(CFG_SPARE, 9'($urandom_range(511)));
            end
            nitems = 58;
            for (int k = 0; k < nitems; k++) begin
                if (ph == 2 && k == 10) hold_token = hold_token + 1;
                if (ph == 5 && k == 30) wait_idle();
                if (ph == 4 && k == 29)
                    write_cfg(amer_pkg::CFG_THRESHOLD, 9'($urandom_range(255)));
                send_pixel(rand_alpha());
            end
        end

        wait_idle();
        if (errors == 0 && expected_runs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
